FILE: hw/rtl/halton_point_generator_top_defines.svh
// ----------------------------------------------------------------------------
// Halton point generator assertion macros
// Shared property shorthands, clocked on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef HALTON_POINT_GENERATOR_TOP_DEFINES_SVH
`define HALTON_POINT_GENERATOR_TOP_DEFINES_SVH

// Same-cycle implication or plain property.
`define HPG_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition in one cycle implies a consequence in the next.
`define HPG_CHECK_NEXT(lbl, cond, conseq, msg) \
  `HPG_CHECK(lbl, (cond) |=> (conseq), msg)

`endif

FILE: hw/rtl/hpg_pkg.sv
// ----------------------------------------------------------------------------
// Halton point generator package
// Field widths and register indexes shared by the generator modules.
// ----------------------------------------------------------------------------
package hpg_pkg;

  localparam int BASE_W    = 8;
  localparam int DIGIT_W   = 8;
  localparam int LIM_W     = 16;
  localparam int SPAN_W    = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 64;
  localparam int COORD_W   = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_BASES  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOWERS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPANS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DIMS   = 3'd3;

  localparam logic [31:0] BASES_RST  = 32'h0203_0405;
  localparam logic [63:0] LOWERS_RST = 64'h0;
  localparam logic [63:0] SPANS_RST  = 64'h0001_0001_0001_0001;
  localparam logic [2:0]  DIMS_RST   = 3'd2;

endpackage

FILE: hw/rtl/hpg_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module hpg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 96
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/hpg_div.sv
// ----------------------------------------------------------------------------
// Radix divider
// Restoring divider, one quotient bit per cycle, by an 8-bit divisor.
// ----------------------------------------------------------------------------
`include "halton_point_generator_top_defines.svh"

module hpg_div #(
  parameter int WIDTH = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [WIDTH-1:0]          dividend,
  input  logic [hpg_pkg::BASE_W-1:0] divisor,
  output logic                      done,
  output logic [WIDTH-1:0]          quotient
);

  localparam int CW = $clog2(WIDTH + 1);

  logic [CW-1:0]              cnt;
  logic [hpg_pkg::BASE_W-1:0] rem;
  logic [hpg_pkg::BASE_W-1:0] dvs;
  logic [hpg_pkg::BASE_W:0]   trial;
  logic [hpg_pkg::BASE_W:0]   diff;
  logic                       ge;

  assign trial = {rem, quotient[WIDTH-1]};
  assign ge    = trial >= {1'b0, dvs};
  assign diff  = trial - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else if (start) begin
      cnt      <= CW'(WIDTH);
      done     <= 1'b0;
      rem      <= '0;
      dvs      <= divisor;
      quotient <= dividend;
    end else begin
      done <= (cnt == CW'(1));
      if (cnt != '0) begin
        cnt      <= cnt - CW'(1);
        rem      <= ge ? diff[hpg_pkg::BASE_W-1:0] : trial[hpg_pkg::BASE_W-1:0];
        quotient <= {quotient[WIDTH-2:0], ge};
      end
    end
  end

  // The partial remainder always stays below the divisor.
  `HPG_CHECK(a_rem_below_divisor, (cnt != '0) |-> (rem < dvs), "remainder not below divisor")
  // Done pulses exactly once after the final quotient bit.
  `HPG_CHECK_NEXT(a_done_after_last, (cnt == CW'(1)) && !start, done, "done missing after last bit")
  `HPG_CHECK(a_done_idle, done |-> (cnt == '0), "done while still iterating")

endmodule

FILE: hw/rtl/halton_point_generator_top.sv
// ----------------------------------------------------------------------------
// Halton point generator
// Multi-dimensional Halton points in signed Q16.16 from per-dimension
// mixed-radix digit counters and precomputed digit weights.
// ----------------------------------------------------------------------------
//  Channel  | Signals                                   | Contents
//  ---------+-------------------------------------------+--------------------------
//  input    | s_tvalid s_tready s_tdata[7:0]            | bit 0 emit
//  output   | m_tvalid m_tready m_tdata m_tuser m_tlast | coordinate, dim/wrapped
//  config   | cfg_valid cfg_ready cfg_index cfg_data    | register write
//
//  After reset and after every register write, a restart pass rebuilds the
//  weight and digit memories: MAX_DIMS*MAX_DIGITS entries, each computed in
//  the bit-serial divider, with no input accepted meanwhile.
//  A request walks the digits of each of the n dimensions in use at one
//  digit per cycle; s_tready also drops for a write.
//  A waiting coordinate holds back the next dimension until its transfer.
// ----------------------------------------------------------------------------
`include "halton_point_generator_top_defines.svh"

module halton_point_generator_top #(
  parameter int MAX_DIMS   = 4,
  parameter int MAX_DIGITS = 24,
  parameter int FRAC_BITS  = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  // Input item: bit 0 emit, bits 7..1 zero.
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [7:0]                    s_tdata,
  // Result: bits 31..0 coordinate.
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [31:0]                   m_tdata,
  // Result: bits 1..0 dim_index, bit 2 wrapped.
  output logic [2:0]                    m_tuser,
  output logic                          m_tlast,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [hpg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [hpg_pkg::CFG_DAT_W-1:0] cfg_data
);

  localparam int DEPTH = MAX_DIMS * MAX_DIGITS;
  localparam int AW    = $clog2(DEPTH);
  localparam int NW    = $clog2(MAX_DIMS + 1);
  localparam int JW    = $clog2(MAX_DIGITS + 1);
  localparam int WW    = hpg_pkg::SPAN_W + FRAC_BITS;
  localparam int PW    = hpg_pkg::DIGIT_W + WW;
  localparam int ACC_W = (FRAC_BITS + 20 > 33) ? FRAC_BITS + 20 : 33;
  localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'($signed(32'h7FFF_FFFF));
  localparam logic signed [ACC_W-1:0] SAT_MIN = ACC_W'($signed(32'h8000_0000));

  typedef enum logic [2:0] {
    S_INIT_START,
    S_INIT_WAIT,
    S_IDLE,
    S_DIM,
    S_OUT
  } state_t;

  state_t state;

  // Configuration registers.
  logic [31:0] bases;
  logic [63:0] lowers;
  logic [63:0] spans;
  logic [2:0]  dims;

  // Sequencer registers.
  logic [NW-1:0] dim;
  logic [JW-1:0] init_j;
  logic [JW-1:0] iss_j;
  logic [AW-1:0] addr_ptr;
  logic [AW-1:0] wb_addr;
  logic          rd_v;
  logic          p_v;
  logic          carry;
  logic          emit;
  logic [WW-1:0] w_prev;
  logic [PW-1:0] prod;
  logic signed [ACC_W-1:0] acc;

  // Output register.
  logic [31:0] coord_q;
  logic [1:0]  dim_q;
  logic        wrap_q;
  logic        last_q;
  logic        out_valid;

  function automatic logic [hpg_pkg::BASE_W-1:0] base_of(input logic [3:0] dd,
                                                         input logic [31:0] bp);
    logic [hpg_pkg::BASE_W-1:0] b;
    b = '0;
    if (dd < 4'd4) begin
      b = bp[8*dd[1:0] +: 8];
    end
    return (b < 8'd2) ? 8'd2 : b;
  endfunction

  function automatic logic [hpg_pkg::SPAN_W-1:0] span_of(input logic [3:0] dd,
                                                         input logic [63:0] sp);
    return (dd < 4'd4) ? sp[16*dd[1:0] +: 16] : '0;
  endfunction

  function automatic logic signed [ACC_W-1:0] lower_of(input logic [3:0] dd,
                                                       input logic [63:0] lp);
    logic [hpg_pkg::LIM_W-1:0] lo;
    lo = (dd < 4'd4) ? lp[16*dd[1:0] +: 16] : '0;
    return {{(ACC_W - hpg_pkg::LIM_W - FRAC_BITS){lo[hpg_pkg::LIM_W-1]}}, lo,
            {FRAC_BITS{1'b0}}};
  endfunction

  // Effective dimension count, clamped into 1..MAX_DIMS.
  logic [NW-1:0] n_dims;
  always_comb begin
    if (dims == 3'd0) begin
      n_dims = NW'(1);
    end else if (int'(dims) > MAX_DIMS) begin
      n_dims = NW'(MAX_DIMS);
    end else begin
      n_dims = NW'(dims);
    end
  end

  logic [NW-1:0] dim_nx;
  assign dim_nx = dim + NW'(1);

  logic [hpg_pkg::BASE_W-1:0] base_cur;
  assign base_cur = base_of(4'(dim), bases);

  // Divider hookup for the restart pass.
  logic          div_start;
  logic          div_done;
  logic [WW-1:0] div_quo;
  logic [WW-1:0] div_dividend;

  assign div_start    = (state == S_INIT_START);
  assign div_dividend = (init_j == '0) ? {span_of(4'(dim), spans), {FRAC_BITS{1'b0}}}
                                       : w_prev;

  hpg_div #(.WIDTH(WW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (base_cur),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Memory ports.
  logic                        init_wr;
  logic                        issue;
  logic                        dig_we;
  logic [AW-1:0]               dig_waddr;
  logic [hpg_pkg::DIGIT_W-1:0] dig_wdata;
  logic [hpg_pkg::DIGIT_W-1:0] dig_q;
  logic [WW-1:0]               wgt_q;
  logic [hpg_pkg::DIGIT_W:0]   inc;
  logic                        inc_fits;

  assign init_wr  = (state == S_INIT_WAIT) && div_done;
  assign issue    = (state == S_DIM) && (iss_j != JW'(MAX_DIGITS));
  assign inc      = {1'b0, dig_q} + 9'd1;
  assign inc_fits = inc < {1'b0, base_cur};

  always_comb begin
    if (init_wr) begin
      dig_we    = 1'b1;
      dig_waddr = addr_ptr;
      dig_wdata = (init_j == '0) ? 8'd1 : 8'd0;
    end else begin
      dig_we    = (state == S_DIM) && rd_v && carry;
      dig_waddr = wb_addr;
      dig_wdata = inc_fits ? inc[hpg_pkg::DIGIT_W-1:0] : 8'd0;
    end
  end

  hpg_ram #(.WIDTH(hpg_pkg::DIGIT_W), .DEPTH(DEPTH)) u_digits (
    .clk   (clk),
    .we    (dig_we),
    .waddr (dig_waddr),
    .wdata (dig_wdata),
    .raddr (addr_ptr),
    .rdata (dig_q)
  );

  hpg_ram #(.WIDTH(WW), .DEPTH(DEPTH)) u_weights (
    .clk   (clk),
    .we    (init_wr),
    .waddr (addr_ptr),
    .wdata (div_quo),
    .raddr (addr_ptr),
    .rdata (wgt_q)
  );

  // Saturated coordinate of the finished dimension.
  logic signed [ACC_W-1:0] acc_sat;
  assign acc_sat = (acc > SAT_MAX) ? SAT_MAX : ((acc < SAT_MIN) ? SAT_MIN : acc);

  // Every digit of the current dimension has left the pipeline.
  logic walk_done;
  assign walk_done = (iss_j == JW'(MAX_DIGITS)) && !rd_v && !p_v;

  logic cfg_hit;
  logic out_free;
  assign cfg_hit  = cfg_valid && (cfg_index <= hpg_pkg::CFG_DIMS);
  assign out_free = !out_valid || m_tready;

  // A register write takes priority, so no request is taken in its cycle.
  assign cfg_ready = 1'b1;
  assign s_tready  = (state == S_IDLE) && !cfg_hit;
  assign m_tvalid  = out_valid;
  assign m_tdata   = coord_q;
  assign m_tuser   = {wrap_q, dim_q};
  assign m_tlast   = last_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT_START;
      bases     <= hpg_pkg::BASES_RST;
      lowers    <= hpg_pkg::LOWERS_RST;
      spans     <= hpg_pkg::SPANS_RST;
      dims      <= hpg_pkg::DIMS_RST;
      dim       <= '0;
      init_j    <= '0;
      iss_j     <= '0;
      addr_ptr  <= '0;
      rd_v      <= 1'b0;
      p_v       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && m_tready) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_INIT_START: begin
          state <= S_INIT_WAIT;
        end
        S_INIT_WAIT: begin
          if (div_done) begin
            w_prev   <= div_quo;
            addr_ptr <= addr_ptr + AW'(1);
            state    <= S_INIT_START;
            if (init_j == JW'(MAX_DIGITS - 1)) begin
              init_j <= '0;
              if (dim == NW'(MAX_DIMS - 1)) begin
                dim   <= '0;
                state <= S_IDLE;
              end else begin
                dim <= dim_nx;
              end
            end else begin
              init_j <= init_j + JW'(1);
            end
          end
        end
        S_IDLE: begin
          if (s_tvalid && s_tready) begin
            emit     <= s_tdata[0];
            dim      <= '0;
            addr_ptr <= '0;
            iss_j    <= '0;
            carry    <= 1'b1;
            rd_v     <= 1'b0;
            p_v      <= 1'b0;
            acc      <= lower_of(4'd0, lowers);
            state    <= S_DIM;
          end
        end
        S_DIM: begin
          // Read stage: one digit and weight per cycle.
          rd_v <= issue;
          if (issue) begin
            wb_addr  <= addr_ptr;
            addr_ptr <= addr_ptr + AW'(1);
            iss_j    <= iss_j + JW'(1);
          end
          // Multiply stage, with the counter increment written back.
          p_v <= rd_v;
          if (rd_v) begin
            prod <= PW'(dig_q) * PW'(wgt_q);
            if (carry && inc_fits) begin
              carry <= 1'b0;
            end
          end
          // Accumulate stage.
          if (p_v) begin
            acc <= acc + $signed(ACC_W'(prod));
          end
          if (!issue && !rd_v && !p_v) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!emit || out_free) begin
            if (emit) begin
              out_valid <= 1'b1;
              coord_q   <= acc_sat[31:0];
              dim_q     <= 2'(dim);
              wrap_q    <= carry;
              last_q    <= (dim_nx == n_dims);
            end
            if (dim_nx == n_dims) begin
              state <= S_IDLE;
            end else begin
              dim   <= dim_nx;
              iss_j <= '0;
              carry <= 1'b1;
              acc   <= lower_of(4'(dim_nx), lowers);
              state <= S_DIM;
            end
          end
        end
        default: begin
          state <= S_INIT_START;
        end
      endcase

      // A register write restarts the generator from its first dimension.
      if (cfg_hit) begin
        case (cfg_index)
          hpg_pkg::CFG_BASES:  bases  <= cfg_data[31:0];
          hpg_pkg::CFG_LOWERS: lowers <= cfg_data;
          hpg_pkg::CFG_SPANS:  spans  <= cfg_data;
          hpg_pkg::CFG_DIMS:   dims   <= cfg_data[2:0];
          default: ;
        endcase
        state    <= S_INIT_START;
        dim      <= '0;
        init_j   <= '0;
        addr_ptr <= '0;
        rd_v     <= 1'b0;
        p_v      <= 1'b0;
      end
    end
  end

  // A dimension finishes only once every digit has gone through all stages.
  `HPG_CHECK(a_out_after_digits, (state == S_OUT) |-> walk_done, "dimension closed early")
  // The digit write-back never lands on the address being read.
  `HPG_CHECK(a_no_rw_clash, (issue && rd_v) |-> (wb_addr != addr_ptr), "digit r/w clash")
  // An accepted item starts the digit walk in the next cycle.
  `HPG_CHECK_NEXT(a_accept_starts, s_tvalid && s_tready, state == S_DIM, "item not started")

endmodule
